// ===== sv/weighted_random_walk_restart_defines.svh =====
// ---------------------------------------------------------------------------
// Weighted random walk with restart: assertion macros
// Shared concurrent check shapes used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_WALK_RESTART_DEFINES_SVH
`define WEIGHTED_RANDOM_WALK_RESTART_DEFINES_SVH

// same-cycle implication
`define WRWR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wrwr same-cycle check failed");

// next-cycle implication
`define WRWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wrwr next-cycle check failed");

`endif

// ===== sv/wrwr_pkg.sv =====
// ---------------------------------------------------------------------------
// Weighted random walk with restart: package
// Request codes, register map and control structs shared by the modules.
// ---------------------------------------------------------------------------
package wrwr_pkg;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  localparam logic REG_RESTART = 1'b0;
  localparam logic REG_LENGTH  = 1'b1;

  localparam int DRAW_BITS = 16;
  localparam int LEN_BITS  = 11;
  localparam logic [LEN_BITS-1:0] MAX_WALK    = 11'd1024;
  localparam logic [LEN_BITS-1:0] LEN_RESET   = 11'd16;

  typedef struct packed {
    logic wr;
    logic scan;
  } wrwr_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wrwr_stat_t;

endpackage

// ===== sv/wrwr_row_walker.sv =====
// ---------------------------------------------------------------------------
// Row walker
// Holds the affinity matrix in one synchronous memory and picks the next
// node of a row: one pass sums the row, a second pass finds the first
// column whose running sum reaches the scaled draw.
// ---------------------------------------------------------------------------
module wrwr_row_walker
  import wrwr_pkg::*;
#(
  parameter int NODES       = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wrwr_ctl_t                     ctl,
  input  logic [$clog2(NODES)-1:0]      wr_row,
  input  logic [$clog2(NODES)-1:0]      wr_col,
  input  logic [((WEIGHT_BITS < 16) ? WEIGHT_BITS : 16)-1:0] wr_data,
  input  logic [$clog2(NODES)-1:0]      scan_row,
  input  logic [DRAW_BITS-1:0]          scan_draw,
  output wrwr_stat_t                    stat,
  output logic [$clog2(NODES)-1:0]      chosen_node
);

  localparam int NW = $clog2(NODES);
  localparam int CW = NW + 1;
  localparam int AW = 2 * NW;
  localparam int WW = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int SW = WW + NW;
  localparam int PW = DRAW_BITS + SW;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_SUM  = 2'd1;
  localparam logic [1:0] P_MUL  = 2'd2;
  localparam logic [1:0] P_SCAN = 2'd3;

  logic [WW-1:0]        mem [0:(1 << AW)-1];
  logic [WW-1:0]        rdata;
  logic [AW-1:0]        addr;
  logic [1:0]           phase;
  logic [CW-1:0]        cnt;
  logic                 issue;
  logic                 rd_vld;
  logic [NW-1:0]        rd_col;
  logic [NW-1:0]        row_q;
  logic [DRAW_BITS-1:0] draw_q;
  logic [SW-1:0]        acc;
  logic [SW-1:0]        acc_next;
  logic [SW-1:0]        thr;
  logic [PW-1:0]        prod;
  logic                 done;
  logic                 cnt_end;

  assign cnt_end  = (cnt == CW'(NODES));
  assign issue    = ((phase == P_SUM) || (phase == P_SCAN)) && !cnt_end;
  assign addr     = ctl.wr ? {wr_row, wr_col} : {row_q, cnt[NW-1:0]};
  assign acc_next = acc + SW'(rdata);
  assign prod     = PW'(draw_q) * PW'(acc);

  assign stat.busy = (phase != P_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wr_data;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= P_IDLE;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      rd_vld <= issue;
      rd_col <= cnt[NW-1:0];
      done   <= 1'b0;
      if (issue) begin
        cnt <= cnt + CW'(1);
      end
      case (phase)
        P_IDLE: begin
          if (ctl.scan) begin
            row_q  <= scan_row;
            draw_q <= scan_draw;
            cnt    <= '0;
            acc    <= '0;
            phase  <= P_SUM;
          end
        end
        P_SUM: begin
          if (rd_vld) begin
            acc <= acc_next;
          end
          if (cnt_end && !rd_vld) begin
            phase <= P_MUL;
          end
        end
        P_MUL: begin
          thr   <= prod[DRAW_BITS +: SW];
          acc   <= '0;
          cnt   <= '0;
          phase <= P_SCAN;
        end
        P_SCAN: begin
          if (rd_vld) begin
            acc <= acc_next;
          end
          if (rd_vld && (thr <= acc_next)) begin
            chosen_node <= rd_col;
            done        <= 1'b1;
            phase       <= P_IDLE;
          end else if (cnt_end && !rd_vld) begin
            chosen_node <= NW'(NODES - 1);
            done        <= 1'b1;
            phase       <= P_IDLE;
          end
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/weighted_random_walk_restart.sv =====
// ---------------------------------------------------------------------------
// Weighted random walk with restart
// Walks an affinity matrix held in on-chip memory, one node per step word.
// ---------------------------------------------------------------------------
// Write, start and restarting step words may follow back to back. A step
// that moves along the matrix reads its row twice through the single memory
// read port, once to sum it and once to find the chosen column, and no new
// word is taken until it is done. The matrix must be loaded before any row
// is walked; rows are not cleared at reset. A new word is taken only while
// the output register is empty or being read in the same cycle.
`include "weighted_random_walk_restart_defines.svh"

module weighted_random_walk_restart
  import wrwr_pkg::*;
#(
  parameter int NODES       = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  row,
  input  logic [7:0]  col,
  input  logic [15:0] weight,
  input  logic [7:0]  start_node,
  input  logic [15:0] rand_restart,
  input  logic [15:0] rand_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  node,
  output logic [9:0]  step_index,
  output logic        last_in_walk
);

  localparam int NW = $clog2(NODES);
  localparam int WW = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  logic                 top_state;
  logic [15:0]          restart_prob;
  logic [LEN_BITS-1:0]  walk_length;
  logic [LEN_BITS-1:0]  eff_len;
  logic [LEN_BITS-1:0]  step_count;
  logic [NW-1:0]        cur_node;
  logic [NW-1:0]        origin;
  logic [NW-1:0]        start_clamped;
  logic [NW-1:0]        chosen_node;
  logic                 in_fire;
  logic                 cfg_wr;
  logic                 wr_in_range;
  logic                 step_live;
  logic                 step_last;
  logic                 restart_hit;
  wrwr_ctl_t            ctl;
  wrwr_stat_t           stat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_LENGTH) ? 32'(walk_length) : 32'(restart_prob);

  assign in_ready = (top_state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign eff_len = (walk_length == '0) ? LEN_BITS'(1) :
                   (walk_length > MAX_WALK) ? MAX_WALK : walk_length;

  assign wr_in_range   = (32'(row) < NODES) && (32'(col) < NODES);
  assign start_clamped = (32'(start_node) >= NODES) ? NW'(NODES - 1) : NW'(start_node);
  assign step_live     = (step_count != '0) && (step_count < eff_len);
  assign step_last     = ((step_count + LEN_BITS'(1)) >= eff_len);
  assign restart_hit   = (rand_restart < restart_prob);

  assign ctl.wr   = in_fire && (req_type == REQ_WRITE) && wr_in_range;
  assign ctl.scan = in_fire && (req_type == REQ_STEP) && step_live && !restart_hit;

  wrwr_row_walker #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .wr_row      (NW'(row)),
    .wr_col      (NW'(col)),
    .wr_data     (WW'(weight)),
    .scan_row    (cur_node),
    .scan_draw   (rand_select),
    .stat        (stat),
    .chosen_node (chosen_node)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      restart_prob <= '0;
      walk_length  <= LEN_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_RESTART: restart_prob <= pwdata[15:0];
        REG_LENGTH:  walk_length  <= pwdata[LEN_BITS-1:0];
        default:     restart_prob <= restart_prob;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_state  <= S_IDLE;
      out_valid  <= 1'b0;
      step_count <= '0;
      cur_node   <= '0;
      origin     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (top_state)
        S_IDLE: begin
          if (in_fire) begin
            case (req_type)
              REQ_START: begin
                origin       <= start_clamped;
                cur_node     <= start_clamped;
                step_count   <= LEN_BITS'(1);
                node         <= 8'(start_clamped);
                step_index   <= '0;
                last_in_walk <= (eff_len <= LEN_BITS'(1));
                out_valid    <= 1'b1;
              end
              REQ_STEP: begin
                if (step_live && restart_hit) begin
                  cur_node     <= origin;
                  step_count   <= step_count + LEN_BITS'(1);
                  node         <= 8'(origin);
                  step_index   <= step_count[9:0];
                  last_in_walk <= step_last;
                  out_valid    <= 1'b1;
                end else if (step_live) begin
                  top_state <= S_WAIT;
                end
              end
              default: begin
                top_state <= S_IDLE;
              end
            endcase
          end
        end
        S_WAIT: begin
          if (stat.done) begin
            cur_node     <= chosen_node;
            step_count   <= step_count + LEN_BITS'(1);
            node         <= 8'(chosen_node);
            step_index   <= step_count[9:0];
            last_in_walk <= step_last;
            out_valid    <= 1'b1;
            top_state    <= S_IDLE;
          end
        end
        default: begin
          top_state <= S_IDLE;
        end
      endcase
    end
  end

  `WRWR_ASSERT_IMPL(a_done_in_wait, clk, rst, stat.done, top_state == S_WAIT)
  `WRWR_ASSERT_NEXT(a_scan_busy, clk, rst, ctl.scan, stat.busy)
  `WRWR_ASSERT_IMPL(a_len_cap, clk, rst, 1'b1, step_count <= MAX_WALK)
  `WRWR_ASSERT_IMPL(a_out_src, clk, rst, $rose(out_valid), $past(in_fire) || $past(stat.done))

endmodule
